FILE: rtl/knn_pkg.sv
// Shared types, codes and sizing constants for the k-nearest-neighbor distance unit.
package knn_pkg;

    // Fixed field widths
    localparam int IDX_BITS     = 10;
    localparam int CNT_BITS     = 11;
    localparam int RANK_BITS    = 10;
    localparam int BW_BITS      = 26;
    localparam int STATUS_BITS  = 2;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DAT_BITS = 11;

    // Parameter defaults
    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 24;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_POINTS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANK   = 1'b1;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_RANK  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_INDEX = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_FWAIT,
        S_PASS,
        S_DRAIN,
        S_DECIDE,
        S_SQSTART,
        S_SQRT,
        S_OUT
    } knn_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_we;
        logic q_start;
        logic fetch_rd;
        logic fetch_latch;
        logic pass_clear;
        logic issue;
        logic decide;
        logic sqrt_start;
        logic sqrt_step;
        logic out_load;
    } knn_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic query_err;
        logic issue_last;
        logic pipe_busy;
        logic bit_last;
        logic sqrt_done;
    } knn_stat_t;

endpackage

FILE: rtl/knn_ctrl.sv
// Sequencer for load, query check, radix selection passes and square root.
module knn_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               cmd,
    input  logic               out_stall,
    input  knn_pkg::knn_stat_t stat,
    output knn_pkg::knn_cmd_t  ctl,
    output logic               in_stall,
    output logic               out_valid
);
    import knn_pkg::*;

    knn_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && cmd == CMD_QUERY)
                    state_next = S_CHECK;
            end
            S_CHECK:   state_next = stat.query_err ? S_OUT : S_FETCH;
            S_FETCH:   state_next = S_FWAIT;
            S_FWAIT:   state_next = S_PASS;
            S_PASS:
            begin
                if (stat.issue_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = S_DECIDE;
            end
            S_DECIDE:  state_next = stat.bit_last ? S_SQSTART : S_PASS;
            S_SQSTART: state_next = S_SQRT;
            S_SQRT:
            begin
                if (stat.sqrt_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath commands and output valid
    always_comb
    begin
        ctl            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.load_we = in_valid && cmd == CMD_LOAD;
                ctl.q_start = in_valid && cmd == CMD_QUERY;
            end
            S_FETCH:   ctl.fetch_rd = 1'b1;
            S_FWAIT:
            begin
                ctl.fetch_latch = 1'b1;
                ctl.pass_clear  = 1'b1;
            end
            S_PASS:    ctl.issue = 1'b1;
            S_DECIDE:
            begin
                ctl.decide     = 1'b1;
                ctl.pass_clear = !stat.bit_last;
            end
            S_SQSTART: ctl.sqrt_start = 1'b1;
            S_SQRT:    ctl.sqrt_step = 1'b1;
            S_OUT:
            begin
                ctl.out_load = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:   ctl = '0;
        endcase
    end

endmodule

FILE: rtl/knn_dpath.sv
// Point store, distance pipeline, rank counter, prefix selection and square root.
module knn_dpath #(
    parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = knn_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  knn_pkg::knn_cmd_t                     ctl,
    output knn_pkg::knn_stat_t                    stat,
    input  logic                                  cfg_we,
    input  logic [knn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [knn_pkg::CFG_DAT_BITS-1:0]      cfg_data,
    input  logic [knn_pkg::IDX_BITS-1:0]          point_index,
    input  logic signed [COORD_BITS-1:0]          x_coord,
    input  logic signed [COORD_BITS-1:0]          y_coord,
    output logic [knn_pkg::BW_BITS-1:0]           bandwidth,
    output logic [knn_pkg::STATUS_BITS-1:0]       status,
    output logic [knn_pkg::IDX_BITS-1:0]          echo_index
);
    import knn_pkg::*;

    localparam int MEM_DEPTH = (MAX_POINTS < (1 << IDX_BITS)) ? MAX_POINTS : (1 << IDX_BITS);
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SQ        = 2 * COORD_BITS + 1;
    localparam int BITW      = $clog2(SQ);
    localparam int SQP       = SQ + (SQ % 2);
    localparam int RW        = SQP / 2;
    localparam int STEPS     = SQP / 2;
    localparam int STW       = $clog2(STEPS);
    localparam int CB        = COORD_BITS;

    // Configuration registers
    logic [CNT_BITS-1:0]  points_reg;
    logic [RANK_BITS-1:0] rank_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg <= CNT_BITS'(1);
            rank_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POINTS: points_reg <= cfg_data[CNT_BITS-1:0];
                REG_RANK:   rank_reg   <= cfg_data[RANK_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // Point store, one write and one registered read port
    logic [CB-1:0]       mem_x [MEM_DEPTH];
    logic [CB-1:0]       mem_y [MEM_DEPTH];
    logic [CB-1:0]       rd_x_reg, rd_y_reg;
    logic [CNT_BITS-1:0] addr_cnt_reg;
    logic [IDX_BITS-1:0] q_idx_reg;
    logic [AW-1:0]       rd_addr;

    assign rd_addr = ctl.fetch_rd ? q_idx_reg[AW-1:0] : addr_cnt_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.load_we && 32'(point_index) < MAX_POINTS)
        begin
            mem_x[point_index[AW-1:0]] <= x_coord;
            mem_y[point_index[AW-1:0]] <= y_coord;
        end
        if (ctl.fetch_rd || ctl.issue)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    // Query check
    logic [CNT_BITS-1:0]    n_eff, n_reg;
    logic [STATUS_BITS-1:0] q_status_reg;

    assign n_eff = (32'(points_reg) > MAX_POINTS) ? CNT_BITS'(MAX_POINTS) : points_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.q_start)
        begin
            q_idx_reg <= point_index;
            n_reg     <= n_eff;
            if (CNT_BITS'(point_index) >= n_eff)
                q_status_reg <= ST_INDEX;
            else if (CNT_BITS'(rank_reg) >= n_eff)
                q_status_reg <= ST_RANK;
            else
                q_status_reg <= ST_OK;
        end
    end

    // Query point latch
    logic signed [CB-1:0] qx_reg, qy_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.fetch_latch)
        begin
            qx_reg <= rd_x_reg;
            qy_reg <= rd_y_reg;
        end
    end

    // Pipeline valid flags
    logic v1_reg, v2_reg, v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Absolute differences
    logic signed [CB:0] dx_s, dy_s;
    logic [CB-1:0]      dx_reg, dy_reg;
    logic [CB:0]        dx_abs, dy_abs;

    assign dx_s   = $signed({rd_x_reg[CB-1], rd_x_reg}) - $signed({qx_reg[CB-1], qx_reg});
    assign dy_s   = $signed({rd_y_reg[CB-1], rd_y_reg}) - $signed({qy_reg[CB-1], qy_reg});
    assign dx_abs = dx_s[CB] ? (CB+1)'(-dx_s) : dx_s;
    assign dy_abs = dy_s[CB] ? (CB+1)'(-dy_s) : dy_s;

    always_ff @(posedge clk)
    begin
        dx_reg <= dx_abs[CB-1:0];
        dy_reg <= dy_abs[CB-1:0];
    end

    // Squares
    logic [2*CB-1:0] sqx_reg, sqy_reg;

    always_ff @(posedge clk)
    begin
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
    end

    // Sum, prefix match and count of zeros at the current bit
    logic [SQ-1:0]        dist_sum;
    logic [SQ-1:0]        hi_mask;
    logic [SQ-1:0]        prefix_reg;
    logic [BITW-1:0]      bit_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [RANK_BITS-1:0] k_reg;
    logic                 hit;

    assign dist_sum = SQ'(sqx_reg) + SQ'(sqy_reg);
    assign hi_mask  = ({SQ{1'b1}} << bit_reg) << 1;
    assign hit      = ((dist_sum & hi_mask) == prefix_reg) && !dist_sum[bit_reg];

    // Address counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_cnt_reg <= '0;
        else if (ctl.pass_clear)
            addr_cnt_reg <= '0;
        else if (ctl.issue)
            addr_cnt_reg <= addr_cnt_reg + CNT_BITS'(1);
    end

    // Radix selection state
    always_ff @(posedge clk)
    begin
        if (ctl.fetch_latch)
        begin
            prefix_reg <= '0;
            bit_reg    <= BITW'(SQ - 1);
            k_reg      <= rank_reg;
        end
        else if (ctl.decide)
        begin
            if (CNT_BITS'(k_reg) >= cnt_reg)
            begin
                k_reg      <= RANK_BITS'(CNT_BITS'(k_reg) - cnt_reg);
                prefix_reg <= prefix_reg | (SQ'(1) << bit_reg);
            end
            bit_reg <= bit_reg - BITW'(1);
        end
        if (ctl.pass_clear)
            cnt_reg <= '0;
        else if (v3_reg && hit)
            cnt_reg <= cnt_reg + CNT_BITS'(1);
    end

    // Square root, two radicand bits a step
    logic [SQP-1:0]  rad_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [STW-1:0]  step_reg;
    logic [RW+1:0]   rem_sh, trial;
    logic [63:0]     root_ext;

    assign rem_sh   = {rem_reg[RW-1:0], rad_reg[SQP-1 -: 2]};
    assign trial    = {root_reg, 2'b01};
    assign root_ext = 64'(root_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.sqrt_start)
        begin
            rad_reg  <= SQP'(prefix_reg);
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end
        else if (ctl.sqrt_step)
        begin
            rad_reg  <= rad_reg << 2;
            step_reg <= step_reg + STW'(1);
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            echo_index <= q_idx_reg;
            status     <= q_status_reg;
            bandwidth  <= (q_status_reg == ST_OK) ? root_ext[BW_BITS-1:0] : '0;
        end
    end

    // Status to the controller
    assign stat.query_err  = (q_status_reg != ST_OK);
    assign stat.issue_last = (addr_cnt_reg == n_reg - CNT_BITS'(1));
    assign stat.pipe_busy  = v1_reg || v2_reg || v3_reg;
    assign stat.bit_last   = (bit_reg == '0);
    assign stat.sqrt_done  = (step_reg == STW'(STEPS - 1));

endmodule

FILE: rtl/knn_distance_bandwidth_unit.sv
// Top level of the k-nearest-neighbor distance unit: controller plus datapath.
//
// Input channel (in_valid / in_stall): a transfer carries cmd, point_index and
// coordinates. A load writes the point in the transfer cycle and gives no result.
// A query gives one result on the output channel (out_valid / out_stall):
// bandwidth, status and echo_index.
// A query takes one selection pass per squared-distance bit (2*COORD_BITS+1 bits,
// 49 at defaults), each pass reading all n points in use in turn through the single
// read port of the point store, then a pipeline drain and a decision; then come
// COORD_BITS+1 square-root steps. Error queries skip the passes and go from the
// check straight to the output register.
// in_stall is high while a query is in progress; a load does not raise it.
// A finished result waits in an output register while out_stall is high; the
// next item may be taken meanwhile, and a later query holds until that register
// is free. Reset clears control and sets points_in_use to 1, neighbor_rank to 0;
// the point store is not cleared. Configuration is written through cfg_we.
module knn_distance_bandwidth_unit #(
    parameter int MAX_POINTS = knn_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = knn_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [knn_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [knn_pkg::CFG_DAT_BITS-1:0]      cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  cmd,
    input  logic [knn_pkg::IDX_BITS-1:0]          point_index,
    input  logic signed [COORD_BITS-1:0]          x_coord,
    input  logic signed [COORD_BITS-1:0]          y_coord,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [knn_pkg::BW_BITS-1:0]           bandwidth,
    output logic [knn_pkg::STATUS_BITS-1:0]       status,
    output logic [knn_pkg::IDX_BITS-1:0]          echo_index
);
    import knn_pkg::*;

    knn_cmd_t  ctl;
    knn_stat_t stat;

    knn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    knn_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_index (point_index),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .bandwidth   (bandwidth),
        .status      (status),
        .echo_index  (echo_index)
    );

    // A query transfer makes the unit busy in the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_QUERY |=> in_stall)
        else $error("query transfer did not start work");

    // Error results carry zero distance
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> bandwidth == '0)
        else $error("error result with nonzero bandwidth");

    // Only defined status codes leave the unit
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_RANK || status == ST_INDEX))
        else $error("undefined status code");

endmodule

FILE: bench/tb_top.sv
// Testbench for the k-nearest-neighbor distance unit: random and directed loads/queries.
`timescale 1ns / 1ps

module tb_top;
    import knn_pkg::*;

    localparam int NPTS = MAX_POINTS_DEF;
    localparam int CB   = COORD_BITS_DEF;

    // Expected result of one query transfer
    typedef struct {
        logic [BW_BITS-1:0]     bw;
        logic [STATUS_BITS-1:0] st;
        logic [IDX_BITS-1:0]    idx;
    } bw_result_t;

    // Point store copy, register copy and queue of pending query results
    class bandwidth_predictor;
        logic signed [CB-1:0] px [NPTS];
        logic signed [CB-1:0] py [NPTS];
        logic [CNT_BITS-1:0]  points_reg;
        logic [RANK_BITS-1:0] rank_reg;
        bw_result_t           pending_bw_q[$];
        int                   errors;

        function new();
            points_reg = 1;
            rank_reg   = 0;
            errors     = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(logic [CFG_IDX_BITS-1:0] ri, logic [CFG_DAT_BITS-1:0] val);
            if (ri == REG_POINTS)
                points_reg = val;
            else if (ri == REG_RANK)
                rank_reg = val[RANK_BITS-1:0];
        endfunction

        // Truncated integer square root
        function logic [63:0] int_sqrt(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [63:0] sq_dist(int a, int b);
            longint dx;
            longint dy;
            dx = longint'(px[a]) - longint'(px[b]);
            dy = longint'(py[a]) - longint'(py[b]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            return dx * dx + dy * dy;
        endfunction

        function void note_input(logic c, logic [IDX_BITS-1:0] pi,
                                 logic signed [CB-1:0] xv, logic signed [CB-1:0] yv);
            bw_result_t  e;
            int          n;
            int          lt;
            int          le;
            logic [63:0] d [NPTS];
            if (c == CMD_LOAD)
            begin
                px[pi] = xv;
                py[pi] = yv;
                return;
            end
            n = (int'(points_reg) > NPTS) ? NPTS : int'(points_reg);
            e.idx = pi;
            e.bw  = 0;
            if (pi >= n)
                e.st = ST_INDEX;
            else if (rank_reg >= n)
                e.st = ST_RANK;
            else
            begin
                e.st = ST_OK;
                for (int i = 0; i < n; i++)
                    d[i] = sq_dist(i, int'(pi));
                // value whose rank span covers the requested rank
                for (int i = 0; i < n; i++)
                begin
                    lt = 0;
                    le = 0;
                    for (int j = 0; j < n; j++)
                    begin
                        if (d[j] < d[i]) lt++;
                        if (d[j] <= d[i]) le++;
                    end
                    if (lt <= rank_reg && rank_reg < le)
                    begin
                        e.bw = BW_BITS'(int_sqrt(d[i]));
                        break;
                    end
                end
            end
            pending_bw_q.push_back(e);
        endfunction

        task check_result(logic [BW_BITS-1:0] bw, logic [STATUS_BITS-1:0] st,
                          logic [IDX_BITS-1:0] ei);
            bw_result_t e;
            if (pending_bw_q.size() == 0)
            begin
                report($sformatf("unexpected result bw=%0d st=%0d idx=%0d", bw, st, ei));
                return;
            end
            e = pending_bw_q.pop_front();
            if (bw !== e.bw)
                report($sformatf("idx %0d bandwidth %0d, want %0d", e.idx, bw, e.bw));
            if (st !== e.st)
                report($sformatf("idx %0d status %0d, want %0d", e.idx, st, e.st));
            if (ei !== e.idx)
                report($sformatf("echo_index %0d, want %0d", ei, e.idx));
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
    logic [CFG_DAT_BITS-1:0]     cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic                        cmd = CMD_LOAD;
    logic [IDX_BITS-1:0]         point_index = '0;
    logic signed [CB-1:0]        x_coord = '0;
    logic signed [CB-1:0]        y_coord = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [BW_BITS-1:0]          bandwidth;
    logic [STATUS_BITS-1:0]      status;
    logic [IDX_BITS-1:0]         echo_index;

    bandwidth_predictor pred = new();
    bit                 no_idle = 1'b1;

    knn_distance_bandwidth_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .point_index(point_index), .x_coord(x_coord), .y_coord(y_coord),
        .out_valid(out_valid), .out_stall(out_stall),
        .bandwidth(bandwidth), .status(status), .echo_index(echo_index)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 12);

    // Result monitor
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            pred.check_result(bandwidth, status, echo_index);

    // One register write; the caller drops cfg_we afterwards
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] ri, int val);
        cfg_we    <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= CFG_DAT_BITS'(val);
        @(posedge clk);
        pred.set_reg(ri, CFG_DAT_BITS'(val));
    endtask

    // One input transfer, with an optional idle gap first
    task automatic send_item(logic c, int pi, logic [31:0] xv, logic [31:0] yv);
        if (!no_idle && $urandom_range(0, 99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        point_index <= IDX_BITS'(pi);
        x_coord     <= xv[CB-1:0];
        y_coord     <= yv[CB-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred.note_input(c, IDX_BITS'(pi), xv[CB-1:0], yv[CB-1:0]);
    endtask

    task automatic query(int pi);
        send_item(CMD_QUERY, pi, $urandom, $urandom);
    endtask

    // Wait out every pending result plus the tail of a load
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pred.pending_bw_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_phase(int n, int k);
        drain();
        write_reg(REG_POINTS, n);
        write_reg(REG_RANK, k);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int n;
        int k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every point that a query may read
        for (int i = 0; i < 16; i++)
            send_item(CMD_LOAD, i, $urandom, $urandom);

        // Directed: reset config, extreme coordinates, ties
        query(0);
        query(1);
        send_item(CMD_LOAD, 0, -8388608, -8388608);
        send_item(CMD_LOAD, 1, 8388607, 8388607);
        send_item(CMD_LOAD, 2, 8388607, 8388607);
        send_item(CMD_LOAD, 3, 8388607, 8388607);
        set_phase(4, 1);
        query(0);
        query(3);
        set_phase(4, 3);
        query(0);
        query(1);
        query(1023);
        // rank equal to count, and index check taking priority
        set_phase(5, 5);
        query(2);
        set_phase(5, 9);
        query(5);
        // zero point count
        set_phase(0, 0);
        query(0);
        // rank error at a single point
        set_phase(1, 1023);
        query(0);

        // Random phases on small point sets
        for (int ph = 0; ph < 6; ph++)
        begin
            n = $urandom_range(2, 12);
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n + 1) : $urandom_range(0, n - 1);
            set_phase(n, k);
            no_idle = (ph == 3);
            for (int it = 0; it < 12; it++)
            begin
                if ($urandom_range(0, 99) < 40)
                    send_item(CMD_LOAD, $urandom_range(0, 15), $urandom, $urandom);
                else if ($urandom_range(0, 9) == 0)
                    query($urandom_range(0, 1023));
                else
                    query($urandom_range(0, n - 1));
            end
        end

        drain();
        if (pred.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Idling off at first (fill, directed), then on except one phase
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        while (pred.points_reg != 1 || pred.rank_reg != 1023)
            @(posedge clk);
        no_idle = 1'b0;
    end

    initial
    begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end
endmodule
